/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers. They are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RMS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `RMS_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define RMS_ASSERT(lbl, clk, rst_n, prop)
`define RMS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/rms_pkg.sv */
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants for the robot mode sequencer.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 16;
    localparam int DIST_W     = 10;
    localparam int VAL_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RAKE_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AIM_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 3'd4;

    localparam logic [TIME_W-1:0] RAKE_TIME_RST  = 16'd2000;
    localparam logic [TIME_W-1:0] FIRE_TIME_RST  = 16'd3000;
    localparam logic [TIME_W-1:0] AIM_TIME_RST   = 16'd1000;
    localparam logic [TIME_W-1:0] HOME_TIME_RST  = 16'd1000;
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = 10'd20;
    localparam logic [DIST_W-1:0] DISTANCE_RST   = 10'd50;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_DISTANCE  = 3'd1,
        CMD_NAVIGATE  = 3'd2,
        CMD_RAKES     = 3'd3,
        CMD_LASER_POS = 3'd4,
        CMD_EMERGENCY = 3'd5,
        CMD_REPORT    = 3'd6,
        CMD_STOP      = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NAV   = 3'd1,
        MODE_RAKE  = 3'd2,
        MODE_AIM   = 3'd3,
        MODE_FIRE  = 3'd4,
        MODE_HOME  = 3'd5,
        MODE_ESTOP = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_NAV       = 4'd1,
        EV_RAKE      = 4'd2,
        EV_RAKE_DONE = 4'd3,
        EV_AIM       = 4'd4,
        EV_AIMED     = 4'd5,
        EV_FIRED     = 4'd6,
        EV_HOME      = 4'd7,
        EV_OBSTACLE  = 4'd8,
        EV_MAN_STOP  = 4'd9,
        EV_CLEARED   = 4'd10,
        EV_STOPPED   = 4'd11,
        EV_REJECTED  = 4'd12,
        EV_REPORT    = 4'd13
    } t_event;

    // Classified command as it travels from the front to the back.
    typedef struct packed {
        t_cmd                     cmd;
        logic                     near;
        logic [DIST_W-1:0]        distance;
        logic signed [VAL_W-1:0]  speed;
        logic signed [VAL_W-1:0]  target_x;
        logic signed [VAL_W-1:0]  target_y;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0] rake_time;
        logic [TIME_W-1:0] fire_time;
        logic [TIME_W-1:0] aim_time;
        logic [TIME_W-1:0] home_time;
    } t_timers;

    typedef struct packed {
        t_mode                    mode;
        t_event                   event_res;
        logic [DIST_W-1:0]        last_distance;
        logic signed [VAL_W-1:0]  nav_speed;
        logic signed [VAL_W-1:0]  laser_x;
        logic signed [VAL_W-1:0]  laser_y;
    } t_result;

endpackage

/* hw/rtl/rms_front.sv */
// ----------------------------------------------------------------------------
// rms_front
// Input register stage: takes a beat, decodes the command and flags
// near distance samples.
// ----------------------------------------------------------------------------
module rms_front import rms_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_cmd                    i_cmd,
    input  logic [DIST_W-1:0]       i_distance,
    input  logic signed [VAL_W-1:0] i_speed,
    input  logic signed [VAL_W-1:0] i_target_x,
    input  logic signed [VAL_W-1:0] i_target_y,
    input  logic [DIST_W-1:0]       i_near_limit,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_item                   o_item
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.cmd      <= i_cmd;
            // zero means no echo; limit of zero never matches
            r_item.near     <= (i_distance != '0) && (i_distance < i_near_limit);
            r_item.distance <= i_distance;
            r_item.speed    <= i_speed;
            r_item.target_x <= i_target_x;
            r_item.target_y <= i_target_y;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hw/rtl/rms_queue.sv */
// ----------------------------------------------------------------------------
// rms_queue
// Two-entry queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
module rms_queue import rms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item = r_mem[r_rd];

endmodule

/* hw/rtl/rms_back.sv */
// ----------------------------------------------------------------------------
// rms_back
// Mode state machine: applies one decoded command per cycle when the
// output is not stalled and registers the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rms_back import rms_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    input  t_timers i_timers,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int CMP_W = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    t_mode                   r_mode, n_mode;
    t_mode                   r_saved_mode, n_saved_mode;
    logic [TIMER_BITS-1:0]   r_elapsed, n_elapsed;
    logic                    r_obstacle, n_obstacle;
    logic [DIST_W-1:0]       r_distance, n_distance;
    logic signed [VAL_W-1:0] r_speed, n_speed;
    logic signed [VAL_W-1:0] r_x, n_x;
    logic signed [VAL_W-1:0] r_y, n_y;
    logic                    r_out_valid;
    t_result                 r_out, n_result;

    logic                    pop;
    logic [TIMER_BITS-1:0]   elapsed_inc;
    logic [CMP_W-1:0]        elapsed_cmp;
    logic                    go;
    t_mode                   target;
    t_event                  evt;

    assign o_ready = !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;

    assign elapsed_inc = (r_elapsed == TIMER_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign elapsed_cmp = CMP_W'(elapsed_inc);

    always_comb begin
        n_mode       = r_mode;
        n_saved_mode = r_saved_mode;
        n_elapsed    = r_elapsed;
        n_obstacle   = r_obstacle;
        n_distance   = r_distance;
        n_speed      = r_speed;
        n_x          = r_x;
        n_y          = r_y;
        go           = 1'b0;
        target       = r_mode;
        evt          = EV_NONE;

        unique case (i_item.cmd)
            CMD_TICK: begin
                n_elapsed = elapsed_inc;
                unique case (r_mode)
                    MODE_RAKE: begin
                        if (elapsed_cmp >= CMP_W'(i_timers.rake_time)) begin
                            go = 1'b1; target = MODE_NAV; evt = EV_RAKE_DONE;
                        end
                    end
                    MODE_AIM: begin
                        if (elapsed_cmp >= CMP_W'(i_timers.aim_time)) begin
                            go = 1'b1; target = MODE_FIRE; evt = EV_AIMED;
                        end
                    end
                    MODE_FIRE: begin
                        if (elapsed_cmp >= CMP_W'(i_timers.fire_time)) begin
                            go = 1'b1; target = MODE_HOME; evt = EV_FIRED;
                        end
                    end
                    MODE_HOME: begin
                        if (elapsed_cmp >= CMP_W'(i_timers.home_time)) begin
                            go = 1'b1; target = MODE_NAV; evt = EV_HOME;
                        end
                    end
                    MODE_ESTOP: begin
                        if (!r_obstacle) begin
                            go = 1'b1; target = r_saved_mode; evt = EV_CLEARED;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_DISTANCE: begin
                n_distance = i_item.distance;
                if (i_item.near) begin
                    // only the rising edge of the obstacle flag trips the stop
                    if (!r_obstacle) begin
                        n_obstacle = 1'b1;
                        if (r_mode != MODE_ESTOP) begin
                            go = 1'b1; target = MODE_ESTOP; evt = EV_OBSTACLE;
                        end
                    end
                end else begin
                    n_obstacle = 1'b0;
                end
            end
            CMD_NAVIGATE: begin
                n_speed = i_item.speed;
                go = 1'b1; target = MODE_NAV; evt = EV_NAV;
            end
            CMD_RAKES: begin
                if (r_mode == MODE_NAV) begin
                    go = 1'b1; target = MODE_RAKE; evt = EV_RAKE;
                end else begin
                    evt = EV_REJECTED;
                end
            end
            CMD_LASER_POS: begin
                n_x = i_item.target_x;
                n_y = i_item.target_y;
                if (r_mode == MODE_NAV) begin
                    go = 1'b1; target = MODE_AIM; evt = EV_AIM;
                end else begin
                    evt = EV_REJECTED;
                end
            end
            CMD_EMERGENCY: begin
                go = 1'b1; target = MODE_ESTOP; evt = EV_MAN_STOP;
            end
            CMD_REPORT: begin
                evt = EV_REPORT;
            end
            CMD_STOP: begin
                go = 1'b1; target = MODE_IDLE; evt = EV_STOPPED;
            end
            default: ;
        endcase

        // same-mode change keeps the timer running
        if (go && (target != r_mode)) begin
            n_saved_mode = r_mode;
            n_mode       = target;
            n_elapsed    = '0;
        end

        n_result.mode          = n_mode;
        n_result.event_res     = evt;
        n_result.last_distance = n_distance;
        n_result.nav_speed     = n_speed;
        n_result.laser_x       = n_x;
        n_result.laser_y       = n_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_saved_mode <= MODE_IDLE;
            r_elapsed    <= '0;
            r_obstacle   <= 1'b0;
            r_distance   <= DISTANCE_RST;
            r_speed      <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_mode       <= n_mode;
                r_saved_mode <= n_saved_mode;
                r_elapsed    <= n_elapsed;
                r_obstacle   <= n_obstacle;
                r_distance   <= n_distance;
                r_speed      <= n_speed;
                r_x          <= n_x;
                r_y          <= n_y;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `RMS_ASSERT(a_mode_change_clears_timer, i_clk, i_rst_n, (r_mode != $past(r_mode)) |-> (r_elapsed == '0))
    `RMS_ASSERT(a_mode_change_saves_old, i_clk, i_rst_n, (r_mode != $past(r_mode)) |-> (r_saved_mode == $past(r_mode)))
    `RMS_ASSERT(a_obstacle_sets_flag, i_clk, i_rst_n, (pop && (evt == EV_OBSTACLE)) |=> (r_obstacle && (r_mode == MODE_ESTOP)))

endmodule

/* hw/rtl/robot_mode_sequencer_core.sv */
// ----------------------------------------------------------------------------
// robot_mode_sequencer_core
// Seven-mode field robot sequencer driven by ticks, distance samples and
// decoded commands; one result beat per input beat.
// ----------------------------------------------------------------------------
// Every input beat (a millisecond tick, an ultrasonic distance sample or a
// decoded command) produces exactly one result beat carrying the mode after
// that beat, an event code and the stored distance, speed and laser target.
// The block sustains one beat per clock when the output is not stalled:
// the input register decodes the command and flags near samples against
// near_limit, a two-entry queue decouples it from the mode machine, and
// the mode machine applies one command per cycle into an output register.
// A beat passes the input register, the queue and the output register
// before its result is valid; the combinational mode update (one timer
// increment and one 16-bit compare) sets the rate. The user must write
// timers over the cfg port only while idle; the block does not enforce
// it. Index 0 rake_time, 1 fire_time, 2 aim_time, 3 home_time, 4
// near_limit (low 10 bits), other indexes are ignored. Elapsed time
// saturates at 2^TIMER_BITS - 1, so a timer above that never expires.
// ----------------------------------------------------------------------------
module robot_mode_sequencer_core import rms_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input beats
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // command[2:0], distance[12:3], speed[28:13], target_x[44:29],
    // target_y[60:45], zero[63:61]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result beats
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // mode[2:0], event_res[6:3], last_distance[16:7], nav_speed[32:17],
    // laser_x[48:33], laser_y[64:49], zero[71:65]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // timer and limit registers
    t_timers           r_timers;
    logic [DIST_W-1:0] r_near_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timers.rake_time <= RAKE_TIME_RST;
            r_timers.fire_time <= FIRE_TIME_RST;
            r_timers.aim_time  <= AIM_TIME_RST;
            r_timers.home_time <= HOME_TIME_RST;
            r_near_limit       <= NEAR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RAKE_TIME:  r_timers.rake_time <= i_cfg_wdata;
                REG_FIRE_TIME:  r_timers.fire_time <= i_cfg_wdata;
                REG_AIM_TIME:   r_timers.aim_time  <= i_cfg_wdata;
                REG_HOME_TIME:  r_timers.home_time <= i_cfg_wdata;
                REG_NEAR_LIMIT: r_near_limit       <= i_cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // front -> queue -> back
    logic    fr_valid, fr_ready;
    t_item   fr_item;
    logic    q_valid, q_ready;
    t_item   q_item;
    t_result result;

    rms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (t_cmd'(s_axis_tdata[2:0])),
        .i_distance   (s_axis_tdata[12:3]),
        .i_speed      (s_axis_tdata[28:13]),
        .i_target_x   (s_axis_tdata[44:29]),
        .i_target_y   (s_axis_tdata[60:45]),
        .i_near_limit (r_near_limit),
        .o_valid      (fr_valid),
        .i_ready      (fr_ready),
        .o_item       (fr_item)
    );

    rms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_item  (fr_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    rms_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_item   (q_item),
        .i_timers (r_timers),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // pack the result beat, first field lowest
    assign m_axis_tdata = {
        7'd0,
        result.laser_y,
        result.laser_x,
        result.nav_speed,
        result.last_distance,
        result.event_res,
        result.mode
    };

endmodule

/* dv/robot_mode_sequencer_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// robot_mode_sequencer_core_tb
// Self-checking bench for the mode sequencer. A directed table exercises every
// command, the timed exits, obstacle entry and clearing, rejected requests and
// field extremes. Random segments follow under several timer and near_limit
// settings. A final run holds rake mode until a longer rake time runs out.
// Every accepted input beat is run through a local mode predictor. Each result
// beat is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module robot_mode_sequencer_core_tb;
    import rms_pkg::*;

    localparam int SEG_COUNT  = 6;
    localparam int SEG_BEATS  = 300;
    localparam int LONG_RAKE  = 20;
    localparam int LONG_TICKS = 24;      // rake exit plus a few ticks in nav
    localparam int DIR_ROWS   = 25;
    localparam int TAIL_WAIT  = 8;       // margin past the input register, queue and output register

    // One input beat as the sender sees it.
    typedef struct packed {
        t_cmd                    cmd;
        logic [DIST_W-1:0]       distance;
        logic signed [VAL_W-1:0] speed;
        logic signed [VAL_W-1:0] tx;
        logic signed [VAL_W-1:0] ty;
    } t_beat;

    // Directed row: a beat plus an optional hand-written mode/event.
    typedef struct packed {
        t_beat  beat;
        logic   pinned;
        t_mode  mode;
        t_event ev;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // command[2:0], distance[12:3], speed[28:13], target_x[44:29],
    // target_y[60:45], zero[63:61]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // mode[2:0], event_res[6:3], last_distance[16:7], nav_speed[32:17],
    // laser_x[48:33], laser_y[64:49], zero[71:65]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    robot_mode_sequencer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Idle rates in percent per cycle for each side of the stream.
    int unsigned src_idle_pct = 13;
    int unsigned dst_idle_pct = 72;
    int          fail_count   = 0;

    // Shadow of the timer / limit registers.
    logic [TIME_W-1:0] rake_ticks = RAKE_TIME_RST;
    logic [TIME_W-1:0] fire_ticks = FIRE_TIME_RST;
    logic [TIME_W-1:0] aim_ticks  = AIM_TIME_RST;
    logic [TIME_W-1:0] home_ticks = HOME_TIME_RST;
    logic [DIST_W-1:0] near_cm    = NEAR_LIMIT_RST;

    // Predicted sequencer state.
    t_mode                   cur_mode    = MODE_IDLE;
    t_mode                   prev_mode   = MODE_IDLE;
    logic [TIME_W-1:0]       mode_age    = '0;
    logic                    obstacle_on = 1'b0;
    logic [DIST_W-1:0]       dist_cm     = DISTANCE_RST;
    logic signed [VAL_W-1:0] speed_q     = '0;
    logic signed [VAL_W-1:0] aim_x       = '0;
    logic signed [VAL_W-1:0] aim_y       = '0;

    // Predicted result beats, oldest first.
    t_result pending_results[$];

    // Directed table. Unpinned rows rely on the predictor alone.
    t_row dir_rows [0:DIR_ROWS-1] = '{
        // after reset: report, then both requests rejected while idle
        '{'{CMD_REPORT,    10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b1, MODE_IDLE, EV_REPORT},
        '{'{CMD_RAKES,     10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b1, MODE_IDLE, EV_REJECTED},
        '{'{CMD_LASER_POS, 10'd0,   16'h0000, 16'h8000, 16'h7FFF}, 1'b1, MODE_IDLE, EV_REJECTED},
        // speed extremes, second navigate command is a same-mode change
        '{'{CMD_NAVIGATE,  10'd0,   16'h8000, 16'h0000, 16'h0000}, 1'b1, MODE_NAV,  EV_NAV},
        '{'{CMD_NAVIGATE,  10'd0,   16'h7FFF, 16'h0000, 16'h0000}, 1'b1, MODE_NAV,  EV_NAV},
        // rake cycle with a one-tick rake time
        '{'{CMD_RAKES,     10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        // laser aim / fire / home with target extremes
        '{'{CMD_LASER_POS, 10'd0,   16'h0000, 16'h7FFF, 16'h8000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        // obstacle while homing, repeat near sample, zero sample clears
        '{'{CMD_DISTANCE,  10'd5,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_DISTANCE,  10'd3,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_DISTANCE,  10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        // manual stop, then a fresh obstacle inside emergency stop
        '{'{CMD_EMERGENCY, 10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_DISTANCE,  10'd7,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_DISTANCE,  10'd1023, 16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        // just below and exactly at near_limit
        '{'{CMD_DISTANCE,  10'd19,  16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_DISTANCE,  10'd20,  16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE},
        '{'{CMD_STOP,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b1, MODE_IDLE, EV_STOPPED},
        '{'{CMD_TICK,      10'd0,   16'h0000, 16'h0000, 16'h0000}, 1'b0, MODE_IDLE, EV_NONE}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // A change to the current mode is a no-op: the age keeps running.
    function automatic void switch_mode(input t_mode next_mode);
        if (next_mode != cur_mode) begin
            prev_mode = cur_mode;
            cur_mode  = next_mode;
            mode_age  = '0;
        end
    endfunction

    function automatic t_result advance_modes(input t_beat b);
        t_result r;
        t_event  ev;
        ev = EV_NONE;
        case (b.cmd)
            CMD_TICK: begin
                // age saturates instead of wrapping
                if (mode_age != '1) mode_age = mode_age + 1'b1;
                case (cur_mode)
                    MODE_RAKE: if (mode_age >= rake_ticks) begin
                        switch_mode(MODE_NAV);
                        ev = EV_RAKE_DONE;
                    end
                    MODE_AIM: if (mode_age >= aim_ticks) begin
                        switch_mode(MODE_FIRE);
                        ev = EV_AIMED;
                    end
                    MODE_FIRE: if (mode_age >= fire_ticks) begin
                        switch_mode(MODE_HOME);
                        ev = EV_FIRED;
                    end
                    MODE_HOME: if (mode_age >= home_ticks) begin
                        switch_mode(MODE_NAV);
                        ev = EV_HOME;
                    end
                    // leave the stop as soon as nothing is near, even
                    // right after a manual stop
                    MODE_ESTOP: if (!obstacle_on) begin
                        switch_mode(prev_mode);
                        ev = EV_CLEARED;
                    end
                    default: ;
                endcase
            end
            CMD_DISTANCE: begin
                dist_cm = b.distance;
                if (b.distance != '0 && b.distance < near_cm) begin
                    // only the rising edge of the obstacle flag acts; inside
                    // the stop it just sets the flag
                    if (!obstacle_on) begin
                        obstacle_on = 1'b1;
                        if (cur_mode != MODE_ESTOP) begin
                            switch_mode(MODE_ESTOP);
                            ev = EV_OBSTACLE;
                        end
                    end
                end else begin
                    obstacle_on = 1'b0;
                end
            end
            CMD_NAVIGATE: begin
                speed_q = b.speed;
                switch_mode(MODE_NAV);
                ev = EV_NAV;
            end
            CMD_RAKES: begin
                if (cur_mode == MODE_NAV) begin
                    switch_mode(MODE_RAKE);
                    ev = EV_RAKE;
                end else begin
                    ev = EV_REJECTED;
                end
            end
            CMD_LASER_POS: begin
                // target is latched even when the request is rejected
                aim_x = b.tx;
                aim_y = b.ty;
                if (cur_mode == MODE_NAV) begin
                    switch_mode(MODE_AIM);
                    ev = EV_AIM;
                end else begin
                    ev = EV_REJECTED;
                end
            end
            CMD_EMERGENCY: begin
                switch_mode(MODE_ESTOP);
                ev = EV_MAN_STOP;
            end
            CMD_REPORT: ev = EV_REPORT;
            default: begin
                switch_mode(MODE_IDLE);
                ev = EV_STOPPED;
            end
        endcase
        r.mode          = cur_mode;
        r.event_res     = ev;
        r.last_distance = dist_cm;
        r.nav_speed     = speed_q;
        r.laser_x       = aim_x;
        r.laser_y       = aim_y;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Ticks lead so the timed exits come around; distances lean toward the
    // near window and its edges. Unused fields carry random noise.
    function automatic t_beat random_beat();
        t_beat       b;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 48)      b.cmd = CMD_TICK;
        else if (r < 62) b.cmd = CMD_DISTANCE;
        else if (r < 70) b.cmd = CMD_NAVIGATE;
        else if (r < 77) b.cmd = CMD_RAKES;
        else if (r < 84) b.cmd = CMD_LASER_POS;
        else if (r < 88) b.cmd = CMD_EMERGENCY;
        else if (r < 94) b.cmd = CMD_REPORT;
        else             b.cmd = CMD_STOP;
        b.speed = VAL_W'($urandom);
        b.tx    = VAL_W'($urandom);
        b.ty    = VAL_W'($urandom);
        case ($urandom_range(9))
            0: b.distance = '0;
            1, 2, 3, 4: begin
                if (near_cm > 1) b.distance = DIST_W'($urandom_range(near_cm - 1, 1));
                else             b.distance = DIST_W'($urandom);
            end
            5: b.distance = near_cm;
            default: b.distance = DIST_W'($urandom);
        endcase
        return b;
    endfunction

    // Present one beat, wait for the handshake, then log its prediction.
    task automatic send_beat(input t_beat b, input logic pinned,
                             input t_mode pin_mode, input t_event pin_ev);
        t_result want;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, b.ty, b.tx, b.speed, b.distance, b.cmd};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        want = advance_modes(b);
        if (pinned) begin
            want.mode      = pin_mode;
            want.event_res = pin_ev;
        end
        pending_results.push_back(want);
    endtask

    // Hold the sender off until every predicted beat has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_RAKE_TIME:  rake_ticks = val;
            REG_FIRE_TIME:  fire_ticks = val;
            REG_AIM_TIME:   aim_ticks  = val;
            REG_HOME_TIME:  home_ticks = val;
            REG_NEAR_LIMIT: near_cm    = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_timers(input logic [TIME_W-1:0] rake, fire, aim, home,
                                input logic [DIST_W-1:0] near);
        set_reg(REG_RAKE_TIME, rake);
        set_reg(REG_FIRE_TIME, fire);
        set_reg(REG_AIM_TIME, aim);
        set_reg(REG_HOME_TIME, home);
        set_reg(REG_NEAR_LIMIT, CFG_DATA_W'(near));
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic bit field_ok(input string name, input logic [VAL_W-1:0] want,
                                    input logic [VAL_W-1:0] got);
        if (got === want) return 1'b1;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        return 1'b0;
    endfunction

    function automatic bit fields_match(input t_result want, input t_result got);
        bit ok;
        ok = 1'b1;
        ok &= field_ok("mode", VAL_W'(want.mode), VAL_W'(got.mode));
        ok &= field_ok("event_res", VAL_W'(want.event_res), VAL_W'(got.event_res));
        ok &= field_ok("last_distance", VAL_W'(want.last_distance),
                       VAL_W'(got.last_distance));
        ok &= field_ok("nav_speed", want.nav_speed, got.nav_speed);
        ok &= field_ok("laser_x", want.laser_x, got.laser_x);
        ok &= field_ok("laser_y", want.laser_y, got.laser_y);
        return ok;
    endfunction

    // Receiver: random backpressure and the scoreboard pop on each beat.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.mode          = t_mode'(m_axis_tdata[2:0]);
            got.event_res     = t_event'(m_axis_tdata[6:3]);
            got.last_distance = m_axis_tdata[16:7];
            got.nav_speed     = m_axis_tdata[32:17];
            got.laser_x       = m_axis_tdata[48:33];
            got.laser_y       = m_axis_tdata[64:49];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (!fields_match(want, got)) fail_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_beat b;
        t_row  step_row;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass: short timers so each timed exit takes a tick or two.
        write_timers(16'd1, 16'd2, 16'd1, 16'd1, 10'd20);
        for (int i = 0; i < DIR_ROWS; i++) begin
            step_row = dir_rows[i];
            send_beat(step_row.beat, step_row.pinned, step_row.mode, step_row.ev);
        end

        // Random segments. Segment 0 has the smallest limits (no sample can
        // be near), segment 1 the largest (timers never run out here).
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == 2) begin
                src_idle_pct = 72;
                dst_idle_pct = 13;
            end
            if (seg == 4) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            drain();
            case (seg)
                0: write_timers(16'd1, 16'd1, 16'd1, 16'd1, 10'd1);
                1: write_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
                default: write_timers(TIME_W'($urandom_range(6, 1)),
                                      TIME_W'($urandom_range(6, 1)),
                                      TIME_W'($urandom_range(6, 1)),
                                      TIME_W'($urandom_range(6, 1)),
                                      DIST_W'($urandom_range(120, 2)));
            endcase
            for (int n = 0; n < SEG_BEATS; n++) begin
                // let the pipeline run dry once mid-stream
                if (seg == 2 && n == SEG_BEATS / 2) drain();
                send_beat(random_beat(), 1'b0, MODE_IDLE, EV_NONE);
            end
        end

        // Longer rake time: the exit must come on exactly the tick where the
        // age reaches it, and later ticks in nav do nothing.
        drain();
        write_timers(TIME_W'(LONG_RAKE), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     DIST_W'($urandom_range(1023, 2)));
        b = random_beat();
        b.cmd = CMD_NAVIGATE;
        send_beat(b, 1'b0, MODE_IDLE, EV_NONE);
        b.cmd = CMD_RAKES;
        send_beat(b, 1'b0, MODE_IDLE, EV_NONE);
        for (int n = 0; n < LONG_TICKS; n++) begin
            b = random_beat();
            b.cmd = CMD_TICK;
            send_beat(b, 1'b0, MODE_IDLE, EV_NONE);
        end

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
